@@ hdl/psfp_pkg.sv @@
// ----------------------------------------------------------------------------
// psfp_pkg
// Shared constants, phase codes and result type of the sensor frame parser.
// ----------------------------------------------------------------------------
package psfp_pkg;

   localparam int BYTE_W     = 8;
   localparam int WORD_W     = 16;
   localparam int LEN_W      = 6;
   localparam int BUF_LEN    = 32;
   localparam int KEPT_BYTES = 6;
   localparam int KEPT_IDX_W = $clog2(KEPT_BYTES);

   localparam logic [BYTE_W-1:0] START_FIRST  = 8'h42;
   localparam logic [BYTE_W-1:0] START_SECOND = 8'h4D;

   // Frame length field carries payload plus the two checksum bytes
   localparam logic [WORD_W-1:0] LEN_OVERHEAD = WORD_W'(2);
   localparam logic [WORD_W-1:0] LEN_MIN      = WORD_W'(3);
   localparam logic [WORD_W-1:0] LEN_MAX      = WORD_W'(BUF_LEN + 2);

   typedef enum logic [2:0] {
      PH_WAIT1   = 3'd0,
      PH_WAIT2   = 3'd1,
      PH_LEN_HI  = 3'd2,
      PH_LEN_LO  = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_CHK_HI  = 3'd5,
      PH_CHK_LO  = 3'd6
   } phase_type;

   typedef struct packed {
      logic              checksum_ok;
      logic [WORD_W-1:0] pm1_value;
      logic [WORD_W-1:0] pm25_value;
      logic [WORD_W-1:0] pm10_value;
   } result_type;

endpackage

@@ hdl/psfp_if.sv @@
// ----------------------------------------------------------------------------
// psfp_if
// Valid/ready channels of the sensor frame parser: received bytes in,
// decoded frame results out.
// ----------------------------------------------------------------------------
interface psfp_req_if;
   import psfp_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface psfp_rsp_if;
   import psfp_pkg::*;

   logic              valid;
   logic              ready;
   logic              checksum_ok;
   logic [WORD_W-1:0] pm1_value;
   logic [WORD_W-1:0] pm25_value;
   logic [WORD_W-1:0] pm10_value;

   modport source (output valid, output checksum_ok, output pm1_value,
                   output pm25_value, output pm10_value, input ready);
   modport sink   (input valid, input checksum_ok, input pm1_value,
                   input pm25_value, input pm10_value, output ready);
endinterface

@@ hdl/particle_sensor_frame_parser.sv @@
// ----------------------------------------------------------------------------
// particle_sensor_frame_parser
// Parses particulate sensor serial frames into checksum flag and PM words.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one received serial byte per transaction (rx_byte).
//   rsp_if carries one transaction per complete frame: checksum_ok and the
//   big-endian pm1/pm2.5/pm10 words from payload bytes 0..5.
//   Unless a byte is held off as below, one byte is taken every cycle and
//   folded into the parser state in the cycle it is accepted, so throughput
//   is one byte per cycle. A result shows on rsp_if in the cycle after its
//   last checksum byte is accepted, and sits in a single result register
//   until taken. While that result waits, bytes keep flowing; only the last
//   checksum byte of the next frame is held off (req_if.ready low) until
//   the register drains or drains in that same cycle.
//   Frames with a bad start pattern or a payload length outside
//   1..BUF_LEN give no result; a checksum mismatch still gives one.
//   Synchronous reset returns the parser to the start-byte hunt, clears
//   the kept payload bytes to zero and empties the result register.
// ----------------------------------------------------------------------------
module particle_sensor_frame_parser (
   input  logic      clock,
   input  logic      reset,
   psfp_req_if.sink  req_if,
   psfp_rsp_if.source rsp_if
);
   import psfp_pkg::*;

   logic       res_load;
   logic       out_free;
   result_type res_data;
   result_type out_data;

   psfp_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_if.valid),
      .in_byte  (req_if.rx_byte),
      .in_ready (req_if.ready),
      .out_free (out_free),
      .res_load (res_load),
      .res_data (res_data)
   );

   psfp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (res_load),
      .load_data (res_data),
      .free      (out_free),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_data  (out_data)
   );

   // Drive result payload
   assign rsp_if.checksum_ok = out_data.checksum_ok;
   assign rsp_if.pm1_value   = out_data.pm1_value;
   assign rsp_if.pm25_value  = out_data.pm25_value;
   assign rsp_if.pm10_value  = out_data.pm10_value;

endmodule

@@ hdl/psfp_parser.sv @@
// ----------------------------------------------------------------------------
// psfp_parser
// Frame hunt state machine, running sum, length check and payload capture.
// Consumes one byte per accepted transaction and flags a result on the last
// checksum byte.
// ----------------------------------------------------------------------------
module psfp_parser (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [psfp_pkg::BYTE_W-1:0] in_byte,
   output logic                       in_ready,
   input  logic                       out_free,
   output logic                       res_load,
   output psfp_pkg::result_type       res_data
);
   import psfp_pkg::*;

   phase_type               phase_ff, phase_in;
   logic [WORD_W-1:0]       sum_ff, sum_in;
   logic [BYTE_W-1:0]       chk_hi_ff, chk_hi_in;
   logic [BYTE_W-1:0]       len_hi_ff, len_hi_in;
   logic [LEN_W-1:0]        plen_ff, plen_in;
   logic [LEN_W-1:0]        pidx_ff, pidx_in;
   logic [BYTE_W-1:0]       kept_ff [KEPT_BYTES];
   logic                    kept_we;

   logic                    take;
   logic [WORD_W-1:0]       sum_add;
   logic [WORD_W-1:0]       total;
   logic [WORD_W-1:0]       plen_full;
   logic [LEN_W-1:0]        pidx_next;
   logic [WORD_W-1:0]       check;

   // Hold the checksum byte only when the result slot cannot take it
   assign in_ready  = (phase_ff != PH_CHK_LO) || out_free;
   assign take      = in_valid && in_ready;

   assign sum_add   = sum_ff + WORD_W'(in_byte);
   assign total     = {len_hi_ff, in_byte};
   assign plen_full = total - LEN_OVERHEAD;
   assign pidx_next = pidx_ff + LEN_W'(1);
   assign check     = {chk_hi_ff, in_byte};

   // Next state of the frame hunt
   always_comb begin
      phase_in  = phase_ff;
      sum_in    = sum_ff;
      chk_hi_in = chk_hi_ff;
      len_hi_in = len_hi_ff;
      plen_in   = plen_ff;
      pidx_in   = pidx_ff;
      kept_we   = 1'b0;
      res_load  = 1'b0;
      if (take) begin
         unique case (phase_ff)
            PH_WAIT2: begin
               if (in_byte == START_SECOND) begin
                  sum_in   = sum_add;
                  phase_in = PH_LEN_HI;
               end else if (in_byte == START_FIRST) begin
                  // retry the same byte as a first start byte
                  sum_in   = WORD_W'(in_byte);
                  phase_in = PH_WAIT2;
               end else begin
                  phase_in = PH_WAIT1;
               end
            end
            PH_LEN_HI: begin
               sum_in    = sum_add;
               len_hi_in = in_byte;
               phase_in  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               sum_in = sum_add;
               if (total >= LEN_MIN && total <= LEN_MAX) begin
                  plen_in  = plen_full[LEN_W-1:0];
                  pidx_in  = '0;
                  phase_in = PH_PAYLOAD;
               end else begin
                  phase_in = PH_WAIT1;
               end
            end
            PH_PAYLOAD: begin
               sum_in  = sum_add;
               kept_we = (pidx_ff < LEN_W'(KEPT_BYTES));
               pidx_in = pidx_next;
               if (pidx_next == plen_ff) begin
                  phase_in = PH_CHK_HI;
               end
            end
            PH_CHK_HI: begin
               chk_hi_in = in_byte;
               phase_in  = PH_CHK_LO;
            end
            PH_CHK_LO: begin
               res_load = 1'b1;
               phase_in = PH_WAIT1;
            end
            default: begin
               // waiting for the first start byte, also the unused code
               if (in_byte == START_FIRST) begin
                  sum_in   = WORD_W'(in_byte);
                  phase_in = PH_WAIT2;
               end else begin
                  phase_in = PH_WAIT1;
               end
            end
         endcase
      end
   end

   // Build the result from the kept payload bytes
   always_comb begin
      res_data.checksum_ok = (check == sum_ff);
      res_data.pm1_value   = {kept_ff[0], kept_ff[1]};
      res_data.pm25_value  = {kept_ff[2], kept_ff[3]};
      res_data.pm10_value  = {kept_ff[4], kept_ff[5]};
   end

   // Advance parser registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WAIT1;
         sum_ff    <= '0;
         chk_hi_ff <= '0;
         len_hi_ff <= '0;
         plen_ff   <= '0;
         pidx_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         sum_ff    <= sum_in;
         chk_hi_ff <= chk_hi_in;
         len_hi_ff <= len_hi_in;
         plen_ff   <= plen_in;
         pidx_ff   <= pidx_in;
      end
   end

   // Capture the first payload bytes; earlier values stay on short frames
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEPT_BYTES; i++) begin
            kept_ff[i] <= '0;
         end
      end else if (kept_we) begin
         kept_ff[pidx_ff[KEPT_IDX_W-1:0]] <= in_byte;
      end
   end

endmodule

@@ hdl/psfp_out_reg.sv @@
// ----------------------------------------------------------------------------
// psfp_out_reg
// Result register of the frame parser: holds one result until the receiver
// takes it.
// ----------------------------------------------------------------------------
module psfp_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  psfp_pkg::result_type load_data,
   output logic                 free,
   output logic                 out_valid,
   input  logic                 out_ready,
   output psfp_pkg::result_type out_data
);
   import psfp_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   // Slot opens when empty or being drained this cycle
   assign free      = !valid_ff || out_ready;
   assign valid_in  = load || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Hold valid until the transaction completes
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load result payload
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

@@ bench/psfp_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// psfp_checker
// Watches both channels of the sensor frame parser, tracks the frame hunt
// on every accepted byte and compares each result transaction with the
// oldest frame result still owed.
// ----------------------------------------------------------------------------
module psfp_checker (
   input  logic clock,
   input  logic reset,
   psfp_req_if  req_mon,
   psfp_rsp_if  rsp_mon,
   output int   mismatch_count,
   output int   results_owed
);
   import psfp_pkg::*;

   // Shadow copy of the parser state
   phase_type         phase;
   logic [WORD_W-1:0] byte_sum;
   logic [WORD_W-1:0] rx_check;
   logic [BYTE_W-1:0] len_hi;
   logic [LEN_W-1:0]  pay_len;
   logic [LEN_W-1:0]  pay_idx;
   logic [BYTE_W-1:0] kept [KEPT_BYTES];

   result_type frame_q [$];
   int         errs;

   initial begin
      mismatch_count = 0;
      results_owed   = 0;
      errs           = 0;
   end

   // Restart the hunt, taking this byte as a possible first start byte
   task automatic seek_start(input logic [BYTE_W-1:0] b);
      if (b == START_FIRST) begin
         byte_sum = WORD_W'(b);
         phase    = PH_WAIT2;
      end else begin
         phase = PH_WAIT1;
      end
   endtask

   // Advance the shadow parser by one byte; queue a result at frame end
   task automatic absorb_byte(input logic [BYTE_W-1:0] b);
      logic [WORD_W-1:0] total;
      result_type        res;
      total = {len_hi, b};
      case (phase)
         PH_WAIT2: begin
            if (b == START_SECOND) begin
               byte_sum = byte_sum + WORD_W'(b);
               phase    = PH_LEN_HI;
            end else begin
               seek_start(b);
            end
         end
         PH_LEN_HI: begin
            byte_sum = byte_sum + WORD_W'(b);
            len_hi   = b;
            phase    = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            byte_sum = byte_sum + WORD_W'(b);
            if (total >= LEN_MIN && total <= LEN_MAX) begin
               pay_len = LEN_W'(total - LEN_OVERHEAD);
               pay_idx = '0;
               phase   = PH_PAYLOAD;
            end else begin
               phase = PH_WAIT1;
            end
         end
         PH_PAYLOAD: begin
            byte_sum = byte_sum + WORD_W'(b);
            if (pay_idx < KEPT_BYTES) kept[pay_idx] = b;
            pay_idx = pay_idx + 1'b1;
            if (pay_idx == pay_len) phase = PH_CHK_HI;
         end
         PH_CHK_HI: begin
            rx_check = {b, 8'h00};
            phase    = PH_CHK_LO;
         end
         PH_CHK_LO: begin
            rx_check        = rx_check + WORD_W'(b);
            phase           = PH_WAIT1;
            res.checksum_ok = (rx_check == byte_sum);
            res.pm1_value   = {kept[0], kept[1]};
            res.pm25_value  = {kept[2], kept[3]};
            res.pm10_value  = {kept[4], kept[5]};
            frame_q.push_back(res);
         end
         default: seek_start(b);
      endcase
   endtask

   task automatic check_field(input string name, input logic [WORD_W-1:0] exp_val,
                              input logic [WORD_W-1:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s mismatch: expected 0x%04h, got 0x%04h", name, exp_val, act_val);
         errs++;
      end
   endtask

   // Track accepted bytes and compare accepted results
   always @(posedge clock) begin
      if (reset) begin
         phase    = PH_WAIT1;
         byte_sum = '0;
         rx_check = '0;
         len_hi   = '0;
         pay_len  = '0;
         pay_idx  = '0;
         foreach (kept[i]) kept[i] = '0;
         frame_q.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) absorb_byte(req_mon.rx_byte);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (frame_q.size() == 0) begin
               $error("result transaction with no frame result owed");
               errs++;
            end else begin
               result_type owed;
               owed = frame_q.pop_front();
               check_field("checksum_ok", WORD_W'(owed.checksum_ok),
                           WORD_W'(rsp_mon.checksum_ok));
               check_field("pm1_value", owed.pm1_value, rsp_mon.pm1_value);
               check_field("pm25_value", owed.pm25_value, rsp_mon.pm25_value);
               check_field("pm10_value", owed.pm10_value, rsp_mon.pm10_value);
            end
         end
      end
      mismatch_count <= errs;
      results_owed   <= frame_q.size();
   end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives serial bytes into the sensor frame parser: directed frames for the
// length limits, start-byte retry, short payloads and bad checksums, then
// random frames mixed with noise and broken headers, with random stalls on
// both channels. The checker beside the block does all comparing.
// ----------------------------------------------------------------------------
module tb;
   import psfp_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_BYTES = 2000;
   localparam int CALM_AFTER   = 1700;
   localparam int DRAIN_CYCLES = 16;

   typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_kind_type;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   results_owed;
   int   sent_bytes  = 0;
   int   cycle_count = 0;
   int   stall_left;
   bit   idling_on   = 1'b1;

   psfp_req_if req_chan ();
   psfp_rsp_if rsp_chan ();

   particle_sensor_frame_parser i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan)
   );

   psfp_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort a run that hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("particle_sensor_frame_parser verification failed");
         $finish;
      end
   end

   // Stall the result channel in random bursts
   initial begin
      rsp_chan.ready = 1'b0;
      stall_left     = 0;
      forever begin
         @(negedge clock);
         if (idling_on && stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left = $urandom_range(0, 9);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Send one byte transaction; entered and left at a falling edge
   task automatic push_byte(input logic [BYTE_W-1:0] b);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent_bytes++;
      @(negedge clock);
   endtask

   task automatic send_header(input logic [WORD_W-1:0] len);
      push_byte(START_FIRST);
      push_byte(START_SECOND);
      push_byte(len[15:8]);
      push_byte(len[7:0]);
   endtask

   // Send a complete frame, optionally with a corrupted checksum
   task automatic send_frame(input int pay_len, input fill_kind_type fill, input bit bad_sum);
      logic [WORD_W-1:0] len;
      logic [WORD_W-1:0] sum;
      logic [WORD_W-1:0] chk;
      logic [BYTE_W-1:0] b;
      len = WORD_W'(pay_len) + LEN_OVERHEAD;
      sum = WORD_W'(START_FIRST) + WORD_W'(START_SECOND) + WORD_W'(len[15:8])
            + WORD_W'(len[7:0]);
      send_header(len);
      for (int i = 0; i < pay_len; i++) begin
         case (fill)
            FILL_ONES:  b = 8'hFF;
            FILL_ZEROS: b = 8'h00;
            default:    b = BYTE_W'($urandom_range(0, 255));
         endcase
         sum = sum + WORD_W'(b);
         push_byte(b);
      end
      chk = bad_sum ? sum ^ WORD_W'($urandom_range(1, 65535)) : sum;
      push_byte(chk[15:8]);
      push_byte(chk[7:0]);
   endtask

   initial begin
      int                pick;
      int                pay_len;
      logic [WORD_W-1:0] len;

      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: noise extremes, shortest frame over reset-cleared bytes
      push_byte(8'h00);
      push_byte(8'hFF);
      send_frame(1, FILL_ONES, 1'b0);
      // Repeated first start byte, then a bad checksum over all-ones payload
      push_byte(START_FIRST);
      send_frame(KEPT_BYTES, FILL_ONES, 1'b1);
      // Wrong second start byte that is no start byte either
      push_byte(START_FIRST);
      push_byte(8'h13);
      // Lengths just outside the limits and a huge one
      send_header(LEN_OVERHEAD);
      send_header(LEN_MAX + 1'b1);
      send_header(16'hFFFF);
      // Longest payload, then a short one keeping earlier bytes
      send_frame(BUF_LEN, FILL_ZEROS, 1'b0);
      send_frame(2, FILL_RANDOM, 1'b0);

      // Hold the sender until every frame result has drained
      req_chan.valid <= 1'b0;
      while (results_owed != 0) @(negedge clock);

      // Random: mostly well-formed frames, plus noise and broken frames
      while (sent_bytes < RANDOM_BYTES) begin
         if (sent_bytes >= CALM_AFTER) idling_on = 1'b0;
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            pay_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, BUF_LEN)
                                                  : $urandom_range(1, 8);
            send_frame(pay_len, FILL_RANDOM, $urandom_range(0, 4) == 0);
         end else if (pick < 80) begin
            repeat ($urandom_range(1, 4)) push_byte(BYTE_W'($urandom_range(0, 255)));
         end else if (pick < 88) begin
            case ($urandom_range(0, 2))
               0:       len = WORD_W'($urandom_range(0, 2));
               1:       len = WORD_W'($urandom_range(BUF_LEN + 3, 255));
               default: len = WORD_W'($urandom_range(256, 65535));
            endcase
            send_header(len);
         end else if (pick < 94) begin
            push_byte(START_FIRST);
            push_byte(BYTE_W'($urandom_range(0, 255)));
         end else begin
            // Cut a frame short; later bytes fill its payload and checksum
            send_header(WORD_W'($urandom_range(3, BUF_LEN + 2)));
            repeat ($urandom_range(0, 4)) push_byte(BYTE_W'($urandom_range(0, 255)));
         end
      end

      // Drain outstanding results, then let the block settle
      req_chan.valid <= 1'b0;
      while (results_owed != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && results_owed == 0) begin
         $display("particle_sensor_frame_parser verification clean");
      end else begin
         $display("particle_sensor_frame_parser verification failed");
      end
      $finish;
   end

endmodule
